// ===== sv/spd_pkg.sv =====
// Shared types, constants and beat formats of the site pattern dedup unit.
package spd_pkg;

	// Default sizes of the pattern store.
	localparam int MAX_TAXA_DEF     = 32;
	localparam int MAX_PATTERNS_DEF = 256;
	localparam int COUNT_BITS_DEF   = 16;

	// Fixed field widths of the beats.
	localparam int CODE_W   = 5;
	localparam int PART_W   = 4;
	localparam int TAXA_W   = 6;
	localparam int PID_W    = 8;
	localparam int TOTAL_W  = 9;
	localparam int RCOUNT_W = 16;
	localparam int TIDX_W   = 5;

	// Configuration port.
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] REG_TAXA_ADDR = 2'd0;
	localparam logic [TAXA_W-1:0] TAXA_RESET    = 6'd4;

	// Lanes per group of the registered select tree.
	localparam int SEL_GROUP = 16;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [PART_W-1:0] part_t;

	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef struct packed {
		func_t              func;
		code_t              base_code;
		logic               site_excluded;
		part_t              site_partition;
		logic [PID_W-1:0]   pattern_index;
		logic [TIDX_W-1:0]  taxon_index;
	} item_beat_t;

	typedef struct packed {
		logic                column_done;
		logic [PID_W-1:0]    pattern_id;
		logic                is_new_pattern;
		logic                was_excluded;
		logic                store_full;
		logic [TOTAL_W-1:0]  pattern_total;
		code_t               read_code;
		logic [RCOUNT_W-1:0] read_count;
		part_t               read_partition;
	} res_beat_t;

	// Controls broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic sweep;
		logic first;
		logic rd_sel;
		logic wr_count;
		logic create;
		logic clear;
	} cell_ctl_t;

endpackage

// ===== sv/site_pattern_dedup_unit.sv =====
// Site pattern dedup unit: collects alignment columns and folds them into unique patterns.
//
// Item channel (item_valid, item_stall, item) takes one beat per taxon code, read or clear.
// Result channel (res_valid, res_stall, res) gives one beat per completed column and per read.
// The APB port holds taxa_in_use at address 0; the user must write it only while the unit
// is idle, as the unit itself does not enforce it. A push that does not end a column leaves
// the unit idle. The last code of a column starts a sweep that broadcasts the buffered column
// to every pattern cell, one taxon per cycle, then two registered select stages and a
// commit state: the result is registered in the commit state, which waits while a stalled
// result holds the output register. An excluded column goes straight to commit.
// A read's result passes the select tree and the commit state, and the next item is
// taken once the unit is back in idle; a clear gives no result.
// The taxon sweep over the column buffer sets the column rate.
// A finished result sits in the output register; the unit still takes new items while it
// waits, and only stops before committing the next result while res_stall holds it.
// Reset empties the pattern store, drops any partly pushed column and sets taxa_in_use to 4.
module site_pattern_dedup_unit
	import spd_pkg::*;
#(
	parameter int MAX_TAXA     = MAX_TAXA_DEF,
	parameter int MAX_PATTERNS = MAX_PATTERNS_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_beat_t        item,
	output logic              res_valid,
	input  logic              res_stall,
	output res_beat_t         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int TIW  = (MAX_TAXA > 1) ? $clog2(MAX_TAXA) : 1;
	localparam int TCW  = $clog2(MAX_TAXA + 1);
	localparam int TXW  = TAXA_W + 1;
	localparam int PW   = $clog2(MAX_PATTERNS);
	localparam int CNTW = $clog2(MAX_PATTERNS + 1);
	localparam int DW   = CODE_W + COUNT_BITS + PART_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_TREE1,
		S_TREE2,
		S_FINISH
	} state_t;

	state_t                state_q;
	logic [TIW-1:0]        pos_q;
	logic [TIW-1:0]        t_q;
	logic [CNTW-1:0]       total_q;
	logic [TAXA_W-1:0]     taxa_q;
	logic                  col_q;
	logic                  excl_q;
	logic                  res_valid_q;
	res_beat_t             res_q;

	code_t                 buf_q [MAX_TAXA];
	logic [TCW-1:0]        n_q;
	part_t                 cpart_q;
	logic [PW-1:0]         idx_q;
	logic [TIW-1:0]        tidx_q;
	logic                  tok_q;
	logic                  pok_q;
	logic [PID_W-1:0]      pid_q;

	logic                  item_take;
	logic                  cfg_wr;
	logic [TCW-1:0]        n_now;
	logic                  pos_last;
	logic                  sweep_last;
	logic                  commit;
	logic                  full;
	cell_ctl_t             ctl;
	logic [TIW-1:0]        tbus;
	logic [PW-1:0]         idx_bus;
	logic [MAX_TAXA-1:0]   wmask;
	logic [COUNT_BITS-1:0] count_wr;
	res_beat_t             res_next;

	logic [MAX_PATTERNS-1:0] occ;
	logic [MAX_PATTERNS-1:0] hit;
	logic [DW-1:0]           cell_data [MAX_PATTERNS];
	code_t                   cell_code [MAX_PATTERNS];
	logic [COUNT_BITS-1:0]   cell_count [MAX_PATTERNS];
	part_t                   cell_part [MAX_PATTERNS];

	logic                  t_any;
	logic [PW-1:0]         t_idx;
	logic [DW-1:0]         t_data;
	code_t                 t_code;
	logic [COUNT_BITS-1:0] t_count;
	part_t                 t_part;

	// Handshakes and configuration access.
	assign item_stall = (state_q != S_IDLE);
	assign item_take  = item_valid & ~item_stall;
	assign cfg_wr     = psel & penable & pwrite & (paddr == REG_TAXA_ADDR);
	assign pready     = 1'b1;
	assign prdata     = (paddr == REG_TAXA_ADDR) ? APB_DW'(taxa_q) : '0;

	// Taxa per column, clamped to the supported range.
	always_comb begin
		if (taxa_q == '0) begin
			n_now = TCW'(1);
		end else if (TXW'(taxa_q) > TXW'(MAX_TAXA)) begin
			n_now = TCW'(MAX_TAXA);
		end else begin
			n_now = TCW'(taxa_q);
		end
	end

	assign pos_last   = (TCW'(pos_q) + TCW'(1)) >= n_now;
	assign sweep_last = (TCW'(t_q) + TCW'(1)) == n_q;
	assign commit     = (state_q == S_FINISH) & (~res_valid_q | ~res_stall);
	assign full       = (total_q == CNTW'(MAX_PATTERNS));

	// Tree output fields.
	assign t_code  = t_data[DW-1 -: CODE_W];
	assign t_count = t_data[PART_W +: COUNT_BITS];
	assign t_part  = t_data[PART_W-1:0];
	assign count_wr = (&t_count) ? t_count : t_count + COUNT_BITS'(1);

	// Controls broadcast to the cell row.
	always_comb begin
		ctl.sweep    = (state_q == S_SWEEP);
		ctl.first    = (t_q == '0);
		ctl.rd_sel   = ~col_q;
		ctl.wr_count = commit & col_q & ~excl_q & t_any;
		ctl.create   = commit & col_q & ~excl_q & ~t_any & ~full;
		ctl.clear    = item_take & (item.func == FUNC_CLEAR);
	end

	assign tbus    = (state_q == S_SWEEP) ? t_q : tidx_q;
	assign idx_bus = col_q ? t_idx : idx_q;

	for (genvar t = 0; t < MAX_TAXA; t++) begin : g_mask
		assign wmask[t] = (TCW'(t) < n_q);
	end

	// Row of pattern cells; each cell sees its left neighbor's occupancy.
	for (genvar k = 0; k < MAX_PATTERNS; k++) begin : g_cell
		logic prev;
		if (k == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_link
			assign prev = occ[k-1];
		end

		spd_cell #(
			.MAX_TAXA   (MAX_TAXA),
			.COUNT_BITS (COUNT_BITS),
			.PW         (PW),
			.TIW        (TIW),
			.CELL_ID    (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.tsel     (tbus),
			.code     (buf_q[t_q]),
			.part     (cpart_q),
			.idx      (idx_bus),
			.count_wr (count_wr),
			.column   (buf_q),
			.wmask    (wmask),
			.prev_occ (prev),
			.occ      (occ[k]),
			.hit      (hit[k]),
			.rd_code  (cell_code[k]),
			.rd_count (cell_count[k]),
			.rd_part  (cell_part[k])
		);

		assign cell_data[k] = {cell_code[k], cell_count[k], cell_part[k]};
	end

	spd_sel_tree #(
		.N  (MAX_PATTERNS),
		.DW (DW),
		.PW (PW)
	) u_tree (
		.clk  (clk),
		.hit  (hit),
		.data (cell_data),
		.any  (t_any),
		.idx  (t_idx),
		.dout (t_data)
	);

	// Result beat built in the commit cycle.
	always_comb begin
		res_next = '0;
		res_next.pattern_total = TOTAL_W'(total_q);
		if (col_q) begin
			res_next.column_done = 1'b1;
			if (excl_q) begin
				res_next.was_excluded = 1'b1;
			end else if (t_any) begin
				res_next.pattern_id = PID_W'(t_idx);
			end else if (full) begin
				res_next.store_full = 1'b1;
			end else begin
				res_next.is_new_pattern = 1'b1;
				res_next.pattern_id     = PID_W'(total_q);
				res_next.pattern_total  = TOTAL_W'(CNTW'(total_q + CNTW'(1)));
			end
		end else begin
			res_next.pattern_id = pid_q;
			if (pok_q) begin
				res_next.read_code      = tok_q ? t_code : '0;
				res_next.read_count     = RCOUNT_W'(t_count);
				res_next.read_partition = t_part;
			end
		end
	end

	// Sequencer, store fill level and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			t_q         <= '0;
			total_q     <= '0;
			taxa_q      <= TAXA_RESET;
			col_q       <= 1'b0;
			excl_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				taxa_q <= pwdata[TAXA_W-1:0];
			end
			// The output register fills on commit and empties when its beat is taken.
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_take) begin
						unique case (item.func)
							FUNC_PUSH: begin
								if (pos_last) begin
									pos_q   <= '0;
									t_q     <= '0;
									col_q   <= 1'b1;
									excl_q  <= item.site_excluded;
									state_q <= item.site_excluded ? S_FINISH : S_SWEEP;
								end else begin
									pos_q <= pos_q + TIW'(1);
								end
							end
							FUNC_READ: begin
								col_q   <= 1'b0;
								excl_q  <= 1'b0;
								state_q <= S_TREE1;
							end
							FUNC_CLEAR: begin
								total_q <= '0;
								pos_q   <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SWEEP: begin
					t_q <= t_q + TIW'(1);
					if (sweep_last) begin
						state_q <= S_TREE1;
					end
				end
				S_TREE1: begin
					state_q <= S_TREE2;
				end
				S_TREE2: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (commit) begin
						if (ctl.create) begin
							total_q <= total_q + CNTW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Column buffer, sampled item fields and the result payload.
	always_ff @(posedge clk) begin
		if (item_take && item.func == FUNC_PUSH) begin
			buf_q[pos_q] <= item.base_code;
			n_q          <= n_now;
			cpart_q      <= item.site_partition;
		end
		if (item_take && item.func == FUNC_READ) begin
			idx_q  <= PW'(item.pattern_index);
			tidx_q <= TIW'(item.taxon_index);
			tok_q  <= (32'(item.taxon_index) < 32'(MAX_TAXA));
			pok_q  <= (32'(item.pattern_index) < 32'(total_q));
			pid_q  <= item.pattern_index;
		end
		if (commit) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/spd_cell.sv =====
// One pattern cell: stores one unique pattern and compares it with the swept column.
module spd_cell
	import spd_pkg::*;
#(
	parameter int MAX_TAXA   = MAX_TAXA_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int PW         = 8,
	parameter int TIW        = 5,
	parameter int CELL_ID    = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl,
	input  logic [TIW-1:0]        tsel,
	input  code_t                 code,
	input  part_t                 part,
	input  logic [PW-1:0]         idx,
	input  logic [COUNT_BITS-1:0] count_wr,
	input  code_t                 column [MAX_TAXA],
	input  logic [MAX_TAXA-1:0]   wmask,
	input  logic                  prev_occ,
	output logic                  occ,
	output logic                  hit,
	output code_t                 rd_code,
	output logic [COUNT_BITS-1:0] rd_count,
	output part_t                 rd_part
);

	code_t                 codes_q [MAX_TAXA];
	part_t                 part_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  occ_q;
	logic                  match_q;
	logic                  me;
	logic                  take;
	logic                  eq;

	// The first free cell is the one whose left neighbor is occupied.
	assign me   = (idx == PW'(CELL_ID));
	assign take = ctl.create & prev_occ & ~occ_q;
	assign eq   = (codes_q[tsel] == code);

	// Occupancy and running match flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				occ_q <= 1'b0;
			end else if (take) begin
				occ_q <= 1'b1;
			end
			if (ctl.sweep) begin
				if (ctl.first) begin
					match_q <= occ_q & (part_q == part) & eq;
				end else begin
					match_q <= match_q & eq;
				end
			end
		end
	end

	// Pattern contents and count; only the taxa in use are written on creation.
	always_ff @(posedge clk) begin
		if (take) begin
			part_q  <= part;
			count_q <= COUNT_BITS'(1);
			for (int t = 0; t < MAX_TAXA; t++) begin
				if (wmask[t]) begin
					codes_q[t] <= column[t];
				end
			end
		end else if (ctl.wr_count && me) begin
			count_q <= count_wr;
		end
	end

	assign occ      = occ_q;
	assign hit      = ctl.rd_sel ? (occ_q & me) : match_q;
	assign rd_code  = codes_q[tsel];
	assign rd_count = count_q;
	assign rd_part  = part_q;

endmodule

// ===== sv/spd_sel_tree.sv =====
// Two-stage registered tree that picks the lowest-numbered cell with its hit flag set.
module spd_sel_tree
	import spd_pkg::*;
#(
	parameter int N  = MAX_PATTERNS_DEF,
	parameter int DW = CODE_W + COUNT_BITS_DEF + PART_W,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic [N-1:0]  hit,
	input  logic [DW-1:0] data [N],
	output logic          any,
	output logic [PW-1:0] idx,
	output logic [DW-1:0] dout
);

	localparam int G   = SEL_GROUP;
	localparam int NG  = (N + G - 1) / G;
	localparam int GW  = $clog2(G);
	localparam int NGW = (NG > 1) ? $clog2(NG) : 1;
	localparam int IW  = NGW + GW;

	logic [NG*G-1:0] hit_p;
	logic [DW-1:0]   data_p [NG*G];
	logic [G-1:0]    grp_oh [NG];
	logic [NG-1:0]   grp_any;
	logic [GW-1:0]   grp_lidx [NG];
	logic [DW-1:0]   grp_dat [NG];

	logic [NG-1:0]   any_s1;
	logic [GW-1:0]   lidx_s1 [NG];
	logic [DW-1:0]   dat_s1 [NG];

	logic [NG-1:0]   top_oh;
	logic [NGW-1:0]  gsel;
	logic [GW-1:0]   lsel;
	logic [DW-1:0]   dsel;

	logic            any_s2;
	logic [IW-1:0]   idx_s2;
	logic [DW-1:0]   dat_s2;

	// Pad the cell row up to whole groups.
	for (genvar k = 0; k < NG * G; k++) begin : g_pad
		if (k < N) begin : g_real
			assign hit_p[k]  = hit[k];
			assign data_p[k] = data[k];
		end else begin : g_fill
			assign hit_p[k]  = 1'b0;
			assign data_p[k] = '0;
		end
	end

	// Lowest set hit of each group as a one-hot vector.
	for (genvar g = 0; g < NG; g++) begin : g_grp
		assign grp_oh[g]  = hit_p[g*G +: G] & (~hit_p[g*G +: G] + G'(1));
		assign grp_any[g] = |hit_p[g*G +: G];
	end

	// First stage: select index and data inside each group.
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_lidx[g] = '0;
			grp_dat[g]  = '0;
			for (int l = 0; l < G; l++) begin
				if (grp_oh[g][l]) begin
					grp_lidx[g] = grp_lidx[g] | GW'(l);
					grp_dat[g]  = grp_dat[g] | data_p[g*G + l];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		any_s1 <= grp_any;
		for (int g = 0; g < NG; g++) begin
			lidx_s1[g] <= grp_lidx[g];
			dat_s1[g]  <= grp_dat[g];
		end
	end

	// Second stage: select the lowest group that has a hit.
	assign top_oh = any_s1 & (~any_s1 + NG'(1));

	always_comb begin
		gsel = '0;
		lsel = '0;
		dsel = '0;
		for (int g = 0; g < NG; g++) begin
			if (top_oh[g]) begin
				gsel = gsel | NGW'(g);
				lsel = lsel | lidx_s1[g];
				dsel = dsel | dat_s1[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		any_s2 <= |any_s1;
		idx_s2 <= {gsel, lsel};
		dat_s2 <= dsel;
	end

	assign any  = any_s2;
	assign idx  = PW'(idx_s2);
	assign dout = dat_s2;

endmodule

// ===== sv/spd_checker.sv =====
// Port-level checker for the site pattern dedup unit, bound to the top level.
module spd_checker
	import spd_pkg::*;
#(
	parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_stall,
	input res_beat_t res
);

	// A stalled result beat stays put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	// A new pattern always takes the last number in the store.
	a_new_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_new_pattern |->
			res.pattern_id == PID_W'(res.pattern_total - TOTAL_W'(1)))
		else $error("new pattern number does not match the pattern total");

	// At most one column outcome, and none on a read beat.
	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $countones({res.is_new_pattern, res.was_excluded, res.store_full}) <= 1
			&& (res.column_done || !(res.is_new_pattern || res.was_excluded || res.store_full)))
		else $error("conflicting outcome flags in result beat");

	// A dropped pattern only happens with the store at capacity.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.store_full |-> res.pattern_total == TOTAL_W'(MAX_PATTERNS))
		else $error("store full reported below capacity");

	// The pattern total never exceeds the store size.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(res.pattern_total) <= 32'(MAX_PATTERNS))
		else $error("pattern total beyond store size");

endmodule

bind site_pattern_dedup_unit spd_checker #(
	.MAX_PATTERNS (MAX_PATTERNS)
) u_spd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
